// ===== rtl/core/tat_pkg.sv =====
// ----------------------------------------------------------------------------
// tat_pkg
// Shared types, register codes and the arctangent table of the tilt angle
// tracker.
// ----------------------------------------------------------------------------
package tat_pkg;

  // fixed field widths of the channels, queue depth and table length
  localparam int SAMPLE_W       = 16;
  localparam int ANGLE_W        = 16;
  localparam int THRESH_W       = 15;
  localparam int GAIN_W         = 9;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int ATAN_TABLE_LEN = 24;

  // item kinds carried in the func field
  localparam logic FUNC_SAMPLE  = 1'b0;
  localparam logic FUNC_REDRAWN = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FLAT_THRESHOLD = 3'd0,
    REG_TILT_THRESHOLD = 3'd1,
    REG_SMOOTHING_GAIN = 3'd2,
    REG_NEGATE_ANGLE   = 3'd3,
    REG_ANGLE_OFFSET   = 3'd4,
    REG_REDRAW_STEP    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] tilt_angle;
    logic                      angle_valid;
    logic                      redraw_needed;
  } out_item_t;

  // configuration as seen by the datapath; the tilt threshold is kept squared
  typedef struct packed {
    logic [THRESH_W-1:0]          flat_threshold;
    logic [2*THRESH_W-1:0]        tilt_sq;
    logic [GAIN_W-1:0]            smoothing_gain;
    logic                         negate_angle;
    logic signed [ANGLE_W-1:0]    angle_offset;
    logic [THRESH_W-1:0]          redraw_step;
  } cfg_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic               func;
    logic               use_sample;
    logic [ANGLE_W-1:0] target;
  } q_item_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN32 [ATAN_TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // table entry rounded half up to angle_bits bits per turn
  function automatic logic [31:0] atan_step(int idx, int angle_bits);
    logic [32:0] sum;
    sum = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - angle_bits));
    return 32'(sum >> (32 - angle_bits));
  endfunction

endpackage

// ===== rtl/core/tat_cfg.sv =====
// ----------------------------------------------------------------------------
// tat_cfg
// Configuration register file; keeps the tilt threshold squared for the
// magnitude test.
// ----------------------------------------------------------------------------
module tat_cfg import tat_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  localparam int TILT_RESET = 3277;

  logic [THRESH_W-1:0]       flat_threshold;
  logic [2*THRESH_W-1:0]     tilt_sq;
  logic [GAIN_W-1:0]         smoothing_gain;
  logic                      negate_angle;
  logic signed [ANGLE_W-1:0] angle_offset;
  logic [THRESH_W-1:0]       redraw_step;

  // writes never stall
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      flat_threshold <= THRESH_W'(6554);
      tilt_sq        <= (2*THRESH_W)'(TILT_RESET * TILT_RESET);
      smoothing_gain <= GAIN_W'(64);
      negate_angle   <= 1'b1;
      angle_offset   <= '0;
      redraw_step    <= THRESH_W'(182);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FLAT_THRESHOLD: flat_threshold <= cfg_data[THRESH_W-1:0];
        REG_TILT_THRESHOLD: tilt_sq <= (2*THRESH_W)'(cfg_data[THRESH_W-1:0]) *
                                       (2*THRESH_W)'(cfg_data[THRESH_W-1:0]);
        REG_SMOOTHING_GAIN: smoothing_gain <= cfg_data[GAIN_W-1:0];
        REG_NEGATE_ANGLE:   negate_angle <= cfg_data[0];
        REG_ANGLE_OFFSET:   angle_offset <= cfg_data;
        REG_REDRAW_STEP:    redraw_step <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.flat_threshold = flat_threshold;
  assign cfg.tilt_sq        = tilt_sq;
  assign cfg.smoothing_gain = smoothing_gain;
  assign cfg.negate_angle   = negate_angle;
  assign cfg.angle_offset   = angle_offset;
  assign cfg.redraw_step    = redraw_step;

endmodule

// ===== rtl/core/tat_front.sv =====
// ----------------------------------------------------------------------------
// tat_front
// Accepts input items, qualifies samples and runs a pipelined vectoring
// CORDIC for atan2, one iteration per stage, then forms the target angle.
// ----------------------------------------------------------------------------
module tat_front import tat_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ANGLE_BITS        = 16,
  parameter int SAMPLE_BITS       = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output logic     fin_valid,
  output q_item_t  fin_item,
  input  logic     fin_ready
);

  localparam int STAGES = (CORDIC_ITERATIONS < ATAN_TABLE_LEN) ?
                          CORDIC_ITERATIONS : ATAN_TABLE_LEN;
  localparam int DW     = SAMPLE_BITS + 3;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int SUM_W  = (SQ_W + 1 > 2 * THRESH_W) ? SQ_W + 1 : 2 * THRESH_W;
  localparam int ZCMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

  logic                          adv;
  logic signed [SAMPLE_BITS-1:0] ax, ay, az;
  logic signed [DW-1:0]          x_in, y_in;
  logic [ANGLE_BITS-1:0]         z_in;
  logic [SAMPLE_BITS-1:0]        absz;
  logic                          flat_ok;
  logic signed [SQ_W-1:0]        sqx_in, sqy_in;
  logic [SQ_W-1:0]               sqx, sqy;

  logic                  st_valid [STAGES+1];
  logic                  st_func  [STAGES+1];
  logic                  st_use   [STAGES+1];
  logic signed [DW-1:0]  st_x     [STAGES+1];
  logic signed [DW-1:0]  st_y     [STAGES+1];
  logic [ANGLE_BITS-1:0] st_z     [STAGES+1];

  logic [ANGLE_W-1:0] th, th_sel, target_c;

  // the whole front moves together unless its last stage is blocked
  assign adv      = !fin_valid || fin_ready;
  assign in_ready = adv;

  // sign extension, or truncation, of the samples to the sample width
  if (SAMPLE_BITS <= SAMPLE_W) begin : g_narrow
    assign ax = in_data.accel_x[SAMPLE_BITS-1:0];
    assign ay = in_data.accel_y[SAMPLE_BITS-1:0];
    assign az = in_data.accel_z[SAMPLE_BITS-1:0];
  end else begin : g_wide
    assign ax = SAMPLE_BITS'(in_data.accel_x);
    assign ay = SAMPLE_BITS'(in_data.accel_y);
    assign az = SAMPLE_BITS'(in_data.accel_z);
  end

  // left half plane is rotated by a half turn; flat test and squares
  always_comb begin
    if (ax[SAMPLE_BITS-1]) begin
      x_in = -DW'(ax);
      y_in = -DW'(ay);
      z_in = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    end else begin
      x_in = DW'(ax);
      y_in = DW'(ay);
      z_in = '0;
    end
    absz    = az[SAMPLE_BITS-1] ? SAMPLE_BITS'(-az) : SAMPLE_BITS'(az);
    flat_ok = ZCMP_W'(absz) < ZCMP_W'(cfg.flat_threshold);
    sqx_in  = ax * ax;
    sqy_in  = ay * ay;
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (adv) begin
      st_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_func[0] <= in_data.func;
      st_use[0]  <= flat_ok;
      st_x[0]    <= x_in;
      st_y[0]    <= y_in;
      st_z[0]    <= z_in;
      sqx        <= SQ_W'(sqx_in);
      sqy        <= SQ_W'(sqy_in);
    end
  end

  // one cordic iteration per stage
  for (genvar k = 0; k < STAGES; k++) begin : g_iter
    localparam logic [ANGLE_BITS-1:0] STEP = ANGLE_BITS'(atan_step(k, ANGLE_BITS));

    logic signed [DW-1:0]  xs, ys, x_nx, y_nx;
    logic [ANGLE_BITS-1:0] z_nx;
    logic                  use_nx;

    always_comb begin
      xs = st_x[k] >>> k;
      ys = st_y[k] >>> k;
      if (!st_y[k][DW-1]) begin
        x_nx = st_x[k] + ys;
        y_nx = st_y[k] - xs;
        z_nx = st_z[k] + STEP;
      end else begin
        x_nx = st_x[k] - ys;
        y_nx = st_y[k] + xs;
        z_nx = st_z[k] - STEP;
      end
    end

    // in-plane magnitude test rides along the first iteration
    if (k == 0) begin : g_mag
      assign use_nx = st_use[k] &&
                      (SUM_W'(sqx) + SUM_W'(sqy) > SUM_W'(cfg.tilt_sq));
    end else begin : g_pass
      assign use_nx = st_use[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else if (adv) begin
        st_valid[k+1] <= st_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_func[k+1] <= st_func[k];
        st_use[k+1]  <= use_nx;
        st_x[k+1]    <= x_nx;
        st_y[k+1]    <= y_nx;
        st_z[k+1]    <= z_nx;
      end
    end
  end

  // accumulated angle to 16 bits
  if (ANGLE_BITS > ANGLE_W) begin : g_round
    logic [ANGLE_BITS:0] zr;
    assign zr = {1'b0, st_z[STAGES]} +
                ((ANGLE_BITS+1)'(1) << (ANGLE_BITS - ANGLE_W - 1));
    assign th = zr[ANGLE_BITS-1 -: ANGLE_W];
  end else if (ANGLE_BITS == ANGLE_W) begin : g_same
    assign th = st_z[STAGES];
  end else begin : g_widen
    assign th = {st_z[STAGES], {(ANGLE_W-ANGLE_BITS){1'b0}}};
  end

  // sign choice and mounting offset
  always_comb begin
    th_sel   = cfg.negate_angle ? (ANGLE_W'(0) - th) : th;
    target_c = th_sel + ANGLE_W'(cfg.angle_offset);
  end

  // target stage feeding the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= st_valid[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_item.func       <= st_func[STAGES];
      fin_item.use_sample <= st_use[STAGES];
      fin_item.target     <= target_c;
    end
  end

endmodule

// ===== rtl/core/tat_queue.sv =====
// ----------------------------------------------------------------------------
// tat_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module tat_queue import tat_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  q_item_t push_item,
  output logic    pop_valid,
  input  logic    pop_ready,
  output q_item_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  q_item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count;
  logic               do_push, do_pop;

  assign push_ready = count != (PTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

// ===== rtl/core/tat_back.sv =====
// ----------------------------------------------------------------------------
// tat_back
// Smoothing accumulator, drawn-angle record and the result register with
// the redraw test.
// ----------------------------------------------------------------------------
module tat_back import tat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  q_item_t   q_item,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [ANGLE_W-1:0]          smoothed, smoothed_next;
  logic [ANGLE_W-1:0]          drawn, drawn_next;
  logic                        seen, seen_next;
  logic                        fire;
  logic signed [ANGLE_W-1:0]   diff;
  logic signed [ANGLE_W+GAIN_W:0] prod;

  logic                        out_full;
  logic [ANGLE_W-1:0]          out_angle, out_drawn;
  logic                        out_seen;
  logic signed [ANGLE_W-1:0]   d;
  logic signed [ANGLE_W:0]     dx, mag;

  // take an item whenever the result register is free or being emptied
  assign q_ready = !out_full || out_ready;
  assign fire    = q_valid && q_ready;

  // state update for one item
  always_comb begin
    diff          = q_item.target - smoothed;
    prod          = diff * $signed({1'b0, cfg.smoothing_gain});
    smoothed_next = smoothed;
    drawn_next    = drawn;
    seen_next     = seen;
    if (q_item.func == FUNC_SAMPLE) begin
      if (q_item.use_sample) begin
        if (!seen) begin
          smoothed_next = q_item.target;
          seen_next     = 1'b1;
        end else begin
          smoothed_next = smoothed + prod[ANGLE_W+7:8];
        end
      end
    end else begin
      drawn_next = smoothed;
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      drawn    <= '0;
      seen     <= 1'b0;
    end else if (fire) begin
      smoothed <= smoothed_next;
      drawn    <= drawn_next;
      seen     <= seen_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (fire) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_angle <= smoothed_next;
      out_drawn <= drawn_next;
      out_seen  <= seen_next;
    end
  end

  // wrapped distance from the drawn angle against the redraw step
  always_comb begin
    d   = out_angle - out_drawn;
    dx  = {d[ANGLE_W-1], d};
    mag = dx[ANGLE_W] ? -dx : dx;
    out_data.tilt_angle    = out_angle;
    out_data.angle_valid   = out_seen;
    out_data.redraw_needed = mag >= $signed({2'b00, cfg.redraw_step});
  end

  assign out_valid = out_full;

endmodule

// ===== rtl/core/tilt_angle_tracker.sv =====
// ----------------------------------------------------------------------------
// tilt_angle_tracker
// Smoothed in-plane tilt angle from accelerometer samples, with a stale flag
// against the last drawn angle.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output side is ready, and gives one
// result per item, in order. The front runs atan2 as a CORDIC pipeline with
// one iteration per stage (at most 24 stages); an item passes the input
// stage, the iteration stages, the target stage, the queue and the result
// register. The sustained rate of one item per cycle is set by the smoothing
// accumulate in the back, the only step that depends on the previous item.
// A four-entry queue separates the front from the back, and the result
// register takes the next item in the same cycle that its waiting result is
// taken. There is no clearing pass after reset. Configuration writes should
// be made while no item is in flight.
module tilt_angle_tracker import tat_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ANGLE_BITS        = 16,
  parameter int SAMPLE_BITS       = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  logic    fin_valid, fin_ready;
  q_item_t fin_item;
  logic    q_valid, q_ready;
  q_item_t q_item;

  // configuration registers
  tat_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // qualification and angle pipeline
  tat_front #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
    .ANGLE_BITS        (ANGLE_BITS),
    .SAMPLE_BITS       (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .fin_valid (fin_valid),
    .fin_item  (fin_item),
    .fin_ready (fin_ready)
  );

  // decoupling queue
  tat_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fin_valid),
    .push_ready (fin_ready),
    .push_item  (fin_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // smoothing and result
  tat_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/tat_checker.sv =====
// ----------------------------------------------------------------------------
// tat_checker
// Port-level checks of the tilt angle tracker, bound to the top level.
// ----------------------------------------------------------------------------
module tat_checker import tat_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      cfg_valid,
  input logic      cfg_ready
);

  logic [7:0] pending;
  logic       seen_out;

  // items accepted but not yet delivered, and whether a valid angle was shown
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      seen_out <= 1'b0;
    end else begin
      pending <= pending + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
      if (out_valid && out_ready && out_data.angle_valid) seen_out <= 1'b1;
    end
  end

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while waiting for transfer");

  // no result without an accepted item behind it
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0)
    else $error("result without a pending item");

  // once shown valid the angle stays valid
  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_out |-> out_data.angle_valid)
    else $error("angle valid dropped");

  // before any usable reading the angle is still at its reset value
  a_angle_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.angle_valid |-> out_data.tilt_angle == '0)
    else $error("angle moved without a usable reading");

  // configuration writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind tilt_angle_tracker tat_checker u_tat_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tilt angle tracker. A clocked driver feeds
// accelerometer samples and redraw marks from a backlog queue, a clocked
// monitor compares every result with the angle tracked by a local CORDIC
// predictor, and both sides idle at random. Register settings change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import tat_pkg::*;

  localparam int CORDIC_STAGES  = 16;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RX_HOLD_CYCLES = 150;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [CORDIC_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor copy of the registers and the tracked state
  logic [THRESH_W-1:0] cfg_flat = 15'd6554;
  logic [THRESH_W-1:0] cfg_tilt = 15'd3277;
  logic [GAIN_W-1:0]   cfg_gain = 9'd64;
  logic                cfg_negate = 1'b1;
  logic [ANGLE_W-1:0]  cfg_offset = 16'd0;
  logic [THRESH_W-1:0] cfg_redraw_step = 15'd182;
  logic [ANGLE_W-1:0]  track_angle = '0;
  logic [ANGLE_W-1:0]  drawn_angle = '0;
  logic                reading_seen = 1'b0;

  in_item_t  item_backlog [$];
  out_item_t expected_tilt [$];
  int        mismatches = 0;
  int        tx_gap = 0;
  int        tx_burst = 0;
  int        rx_stall = 0;
  int        rx_burst = 0;
  int        rx_hold = 0;
  int        rx_hold_req = 0;
  int        rx_hold_served = 0;

  tilt_angle_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // vectoring cordic, left half plane turned by a half turn first
  function automatic logic [ANGLE_W-1:0] cordic_heading(longint x, longint y);
    logic [ANGLE_W-1:0] z;
    logic [31:0]        step;
    longint             xs;
    longint             ys;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 16'h8000;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      step = (ATAN_TURN[i] + 32'd32768) >> 16;
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + step[15:0];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - step[15:0];
      end
    end
    return z;
  endfunction

  // advance the tracked angle by one item and form its result
  function automatic out_item_t advance_tilt(in_item_t it);
    out_item_t          res;
    longint             ax;
    longint             ay;
    longint             az;
    longint             inc;
    logic [ANGLE_W-1:0] target;
    logic [ANGLE_W-1:0] wrap;
    int                 span;
    if (it.func == FUNC_SAMPLE) begin
      ax = $signed(it.accel_x);
      ay = $signed(it.accel_y);
      az = $signed(it.accel_z);
      if (az < 0) az = -az;
      if (az < longint'(cfg_flat) &&
          ax * ax + ay * ay > longint'(cfg_tilt) * longint'(cfg_tilt)) begin
        target = cordic_heading(ax, ay);
        if (cfg_negate) target = 16'd0 - target;
        target = target + cfg_offset;
        if (!reading_seen) begin
          track_angle = target;
          reading_seen = 1'b1;
        end else begin
          wrap = target - track_angle;
          inc = (longint'($signed(wrap)) * longint'(cfg_gain)) >>> 8;
          track_angle = track_angle + inc[15:0];
        end
      end
    end else begin
      drawn_angle = track_angle;
    end
    // half-turn difference counts as 32768 away
    wrap = track_angle - drawn_angle;
    span = $signed(wrap);
    if (span < 0) span = -span;
    res.tilt_angle    = track_angle;
    res.angle_valid   = reading_seen;
    res.redraw_needed = span >= int'(cfg_redraw_step);
    return res;
  endfunction

  // idle length: mostly short, a few long, and stretches of none
  function automatic int idle_len(inout int burst_left);
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int signed_in(int mag);
    return int'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  function automatic in_item_t make_item(logic f, int x, int y, int z);
    in_item_t it;
    it.func    = f;
    it.accel_x = 16'(x);
    it.accel_y = 16'(y);
    it.accel_z = 16'(z);
    return it;
  endfunction

  // mostly usable samples, plus redraw marks, raw noise and rejected ones
  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    int       reach;
    r = $urandom_range(0, 99);
    it = make_item(FUNC_SAMPLE, $urandom, $urandom, $urandom);
    if (r < 15) begin
      it.func = FUNC_REDRAWN;
    end else if (r >= 27) begin
      reach = (r < 35) ? int'(cfg_tilt) + 64 : 32767;
      if (reach > 32767) reach = 32767;
      it.accel_x = 16'(signed_in(reach));
      it.accel_y = 16'(signed_in(reach));
      if (r >= 40 && cfg_flat != 0) it.accel_z = 16'(signed_in(int'(cfg_flat) - 1));
    end
    return it;
  endfunction

  // input driver: one transfer per accepted item, random gaps between
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_tilt.push_back(advance_tilt(in_data));
        tx_gap = idle_len(tx_burst);
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (item_backlog.size() > 0) begin
          in_data <= item_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stalls and requested long hold-offs
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tilt.size() == 0) begin
          $error("result with no item pending: tilt_angle %0d", out_data.tilt_angle);
          mismatches++;
        end else begin
          want = expected_tilt.pop_front();
          if (out_data.tilt_angle !== want.tilt_angle) begin
            $error("tilt_angle expected %0d got %0d", want.tilt_angle, out_data.tilt_angle);
            mismatches++;
          end
          if (out_data.angle_valid !== want.angle_valid) begin
            $error("angle_valid expected %0b got %0b", want.angle_valid,
                   out_data.angle_valid);
            mismatches++;
          end
          if (out_data.redraw_needed !== want.redraw_needed) begin
            $error("redraw_needed expected %0b got %0b", want.redraw_needed,
                   out_data.redraw_needed);
            mismatches++;
          end
        end
      end
      if (rx_hold_req != rx_hold_served) begin
        rx_hold_served = rx_hold_req;
        rx_hold = RX_HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_stall = idle_len(rx_burst);
      end
    end
  end

  // register write transfer, mirrored into the predictor when accepted
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FLAT_THRESHOLD: cfg_flat = val[THRESH_W-1:0];
      REG_TILT_THRESHOLD: cfg_tilt = val[THRESH_W-1:0];
      REG_SMOOTHING_GAIN: cfg_gain = val[GAIN_W-1:0];
      REG_NEGATE_ANGLE:   cfg_negate = val[0];
      REG_ANGLE_OFFSET:   cfg_offset = val;
      REG_REDRAW_STEP:    cfg_redraw_step = val[THRESH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_setting(int flat, int tilt, int gain, int neg, int offset, int step);
    write_reg(REG_FLAT_THRESHOLD, 16'(flat));
    write_reg(REG_TILT_THRESHOLD, 16'(tilt));
    write_reg(REG_SMOOTHING_GAIN, 16'(gain));
    write_reg(REG_NEGATE_ANGLE, 16'(neg));
    write_reg(REG_ANGLE_OFFSET, 16'(offset));
    write_reg(REG_REDRAW_STEP, 16'(step));
  endtask

  // block idle: nothing queued, offered or outstanding, then let it settle
  task automatic wait_idle();
    while (item_backlog.size() != 0 || in_valid || expected_tilt.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(int count, bit squeeze);
    @(negedge clk);
    repeat (count) item_backlog.push_back(random_item());
    if (squeeze) begin
      @(posedge clk);
      rx_hold_req <= rx_hold_req + 1;
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: gates, first reading, axis and corner extremes
    item_backlog.push_back(make_item(FUNC_REDRAWN, 0, 0, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, 3277, 0, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, 8192, 8192, 6554));
    item_backlog.push_back(make_item(FUNC_SAMPLE, 3278, 0, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, 8192, 8192, 6553));
    item_backlog.push_back(make_item(FUNC_SAMPLE, -32768, 0, -6553));
    item_backlog.push_back(make_item(FUNC_SAMPLE, -32768, -32768, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, 32767, 32767, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, 0, -32768, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, 0, 32767, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, -32768, 32767, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, 32767, -32768, 32767));
    item_backlog.push_back(make_item(FUNC_SAMPLE, -32768, -32768, -32768));
    item_backlog.push_back(make_item(FUNC_REDRAWN, -1, -1, -1));
    item_backlog.push_back(make_item(FUNC_SAMPLE, -1, 0, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, -8192, 1, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, -8192, -1, 0));
    item_backlog.push_back(make_item(FUNC_REDRAWN, 0, 0, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, 8192, -8192, 100));
    wait_idle();

    // unity gain, zero tilt threshold, half-turn jumps, then step zero
    write_setting(32767, 0, 256, 0, 32767, 32767);
    @(negedge clk);
    item_backlog.push_back(make_item(FUNC_SAMPLE, 0, 0, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, 1, 0, 0));
    item_backlog.push_back(make_item(FUNC_REDRAWN, 0, 0, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, -8192, 0, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, 8192, 0, 0));
    item_backlog.push_back(make_item(FUNC_SAMPLE, -8192, 0, 0));
    wait_idle();
    write_reg(REG_REDRAW_STEP, 16'd0);
    run_random(120, 1'b0);

    // zero flat threshold rejects every sample
    write_setting(0, 3277, 64, 1, -32768, 32767);
    run_random(40, 1'b0);

    // gain above one, output held off long enough to back up the input
    write_setting(16384, 4000, 511, 1, 1000, 200);
    run_random(130, 1'b1);

    // gain zero freezes the angle after the first reading
    write_setting(8000, 0, 0, 0, -5000, 0);
    run_random(100, 1'b0);

    // top thresholds, gain just above one
    write_setting(32767, 32767, 257, 1, 0, 1);
    run_random(100, 1'b0);

    for (int p = 0; p < 3; p++) begin
      write_setting($urandom_range(2000, 32767), $urandom_range(0, 12000),
                    $urandom_range(0, 511), $urandom_range(0, 1),
                    signed_in(32767), $urandom_range(0, 4000));
      run_random(120, p == 1);
    end

    if (mismatches == 0) begin
      $display("tilt_angle_tracker test passed");
    end else begin
      $display("tilt_angle_tracker test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tilt_angle_tracker test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tat_pkg.sv
rtl/core/tat_cfg.sv
rtl/core/tat_front.sv
rtl/core/tat_queue.sv
rtl/core/tat_back.sv
rtl/core/tilt_angle_tracker.sv
rtl/core/tat_checker.sv
sim/tb.sv
